[rtl/core/pks_pkg.sv]
`timescale 1ns / 1ps

package pks_pkg;

	localparam int DIGIT_W_DEF = 4;

	localparam int POS_W  = 32;
	localparam int QUAT_W = 16;
	localparam int DIST_W = 32;
	localparam int TAN_W  = 18;
	localparam int COS_W  = 16;
	localparam int CNT_W  = 32;
	localparam int IDX_W  = 3;
	localparam int DATA_W = 32;

	localparam logic [TAN_W-1:0]  TAN_RST  = TAN_W'(2288);
	localparam logic [COS_W-1:0]  COS_RST  = COS_W'(32737);
	localparam logic [DIST_W-1:0] DMIN_RST = DIST_W'(32768);
	localparam logic [DIST_W-1:0] DMAX_RST = DIST_W'(6553600);
	localparam logic [DIST_W-1:0] DDEF_RST = DIST_W'(327680);

	typedef enum logic [IDX_W-1:0] {
		REG_TAN  = 3'd0,
		REG_COS  = 3'd1,
		REG_DMIN = 3'd2,
		REG_DMAX = 3'd3,
		REG_DDEF = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		U_IDLE = 3'b001,
		U_RUN  = 3'b010,
		U_ADD  = 3'b100
	} unit_state_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_START = 4'b0010,
		S_WAIT  = 4'b0100,
		S_FIN   = 4'b1000
	} sel_state_t;

	typedef enum logic [1:0] {
		K_RESTART = 2'd0,
		K_FIRST   = 2'd1,
		K_TEST    = 2'd2
	} req_kind_t;

endpackage

[rtl/core/pks_dsmac.sv]
`timescale 1ns / 1ps

module pks_dsmac import pks_pkg::*; #(
	parameter int AW      = 16,
	parameter int BW      = 16,
	parameter int N       = 1,
	parameter int SW      = 32,
	parameter int DIGIT_W = DIGIT_W_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [N-1:0][AW-1:0] a_in,
	input  logic [N-1:0][BW-1:0] b_in,
	input  logic [N-1:0]         neg_in,
	output logic                 done,
	output logic [SW-1:0]        acc
);

	localparam int ND = (BW + DIGIT_W - 1) / DIGIT_W;
	localparam int LW = ND * DIGIT_W;
	localparam int CW = $clog2(ND + 1);
	localparam int TW = $clog2(N + 1);
	localparam int XW = AW + DIGIT_W;

	unit_state_t           ust_q;
	logic [N-1:0][AW-1:0]  a_q;
	logic [N-1:0][LW-1:0]  b_q;
	logic [N-1:0]          neg_q;
	logic [AW-1:0]         hi_q;
	logic [LW-1:0]         lo_q;
	logic [CW-1:0]         dig_q;
	logic [TW-1:0]         left_q;
	logic [SW-1:0]         acc_q;
	logic                  done_q;

	logic [DIGIT_W-1:0]    digit;
	logic [XW-1:0]         pp;
	logic [XW-1:0]         sum;
	logic [AW+LW-1:0]      prod;

	assign digit = b_q[0][DIGIT_W-1:0];
	assign pp    = XW'(a_q[0]) * XW'(digit);
	assign sum   = XW'(hi_q) + pp;
	assign prod  = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ust_q  <= U_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= (ust_q == U_ADD) && (left_q == TW'(1));
			unique case (ust_q)
				U_IDLE: begin
					if (start) begin
						ust_q <= U_RUN;
					end
				end
				U_RUN: begin
					if (dig_q == CW'(ND - 1)) begin
						ust_q <= U_ADD;
					end
				end
				U_ADD: begin
					if (left_q == TW'(1)) begin
						ust_q <= U_IDLE;
					end else begin
						ust_q <= U_RUN;
					end
				end
				default: ust_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ust_q)
			U_IDLE: begin
				if (start) begin
					for (int i = 0; i < N; i++) begin
						a_q[i] <= a_in[i];
						b_q[i] <= LW'(b_in[i]);
					end
					neg_q  <= neg_in;
					hi_q   <= '0;
					lo_q   <= '0;
					dig_q  <= '0;
					left_q <= TW'(N);
					acc_q  <= '0;
				end
			end
			U_RUN: begin
				hi_q    <= sum[XW-1:DIGIT_W];
				lo_q    <= {sum[DIGIT_W-1:0], lo_q[LW-1:DIGIT_W]};
				b_q[0]  <= b_q[0] >> DIGIT_W;
				dig_q   <= dig_q + CW'(1);
			end
			U_ADD: begin
				acc_q  <= neg_q[0] ? acc_q - SW'(prod) : acc_q + SW'(prod);
				for (int i = 0; i < N - 1; i++) begin
					a_q[i]   <= a_q[i+1];
					b_q[i]   <= b_q[i+1];
					neg_q[i] <= neg_q[i+1];
				end
				hi_q   <= '0;
				lo_q   <= '0;
				dig_q  <= '0;
				left_q <= left_q - TW'(1);
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

[rtl/core/pose_keyframe_selector_top.sv]
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// in       input      in_valid / in_ready    op, pos_x/y/z, quat_w/x/y/z, scene_distance
// out      output     out_valid / out_ready  accepted, rejected_count
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a pose test is paced by the squared distance unit, which runs three 33-bit products
// one digit a cycle; restart requests and the first pose after restart go from idle
// straight to the finish state, bypassing the product units
// async reset loads the register defaults and an empty reference, no clearing pass
// one request in flight; the next is taken once the result sits in the output register
// cfg_ready is always high

module pose_keyframe_selector_top import pks_pkg::*; #(
	parameter int DIGIT_W = DIGIT_W_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     op,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic signed [QUAT_W-1:0] quat_w,
	input  logic signed [QUAT_W-1:0] quat_x,
	input  logic signed [QUAT_W-1:0] quat_y,
	input  logic signed [QUAT_W-1:0] quat_z,
	input  logic [DIST_W-1:0]        scene_distance,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     accepted,
	output logic [CNT_W-1:0]         rejected_count,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [IDX_W-1:0]         cfg_index,
	input  logic [DATA_W-1:0]        cfg_data
);

	localparam int MW   = POS_W + 1;
	localparam int THW  = DIST_W + TAN_W;
	localparam int TH2W = 2 * THW;
	localparam int D2W  = 2 * MW + 3;
	localparam int DOTW = 2 * QUAT_W + 3;
	localparam int CMPW = D2W + POS_W;

	logic [TAN_W-1:0]  tan_q;
	logic [COS_W-1:0]  cos_q;
	logic [DIST_W-1:0] dmin_q;
	logic [DIST_W-1:0] dmax_q;
	logic [DIST_W-1:0] ddef_q;

	sel_state_t        st_q;
	req_kind_t         kind_q;
	logic [2:0]        fin_q;
	logic [2:0][POS_W-1:0]  pos_q;
	logic [3:0][QUAT_W-1:0] quat_q;
	logic [2:0][POS_W-1:0]  rpos_q;
	logic [3:0][QUAT_W-1:0] rquat_q;
	logic              have_ref_q;
	logic [DIST_W-1:0] cur_dist_q;
	logic [CNT_W-1:0]  reject_q;
	logic              out_valid_q;
	logic              accepted_q;
	logic [CNT_W-1:0]  count_q;

	logic              in_take;
	logic [DIST_W-1:0] dist_lo;
	logic [DIST_W-1:0] dist_cl;
	logic [2:0][MW-1:0]     mag;
	logic [2:0]             mneg;
	logic [3:0][QUAT_W-1:0] qa;
	logic [3:0][QUAT_W-1:0] qb;
	logic [3:0]             qneg;
	logic              go;
	logic              thr_done;
	logic              th2_done;
	logic              d2_done;
	logic              dot_done;
	logic [THW-1:0]    thr;
	logic [TH2W-1:0]   thr2;
	logic [D2W-1:0]    d2;
	logic [DOTW-1:0]   dot;
	logic [DOTW-1:0]   adot;
	logic [DOTW-1:0]   adot_cl;
	logic              moved;
	logic              turned;
	logic              take_pose;
	logic              out_free;
	logic [CNT_W-1:0]  reject_nx;

	assign cfg_ready = 1'b1;
	assign in_ready  = (st_q == S_IDLE);
	assign in_take   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign dist_lo = (scene_distance < dmin_q) ? dmin_q : scene_distance;
	assign dist_cl = (dist_lo > dmax_q) ? dmax_q : dist_lo;

	always_comb begin
		logic [MW-1:0] diff;
		for (int i = 0; i < 3; i++) begin
			diff    = {pos_q[i][POS_W-1], pos_q[i]} - {rpos_q[i][POS_W-1], rpos_q[i]};
			mneg[i] = diff[MW-1];
			mag[i]  = mneg[i] ? -diff : diff;
		end
		for (int i = 0; i < 4; i++) begin
			qa[i]   = quat_q[i][QUAT_W-1] ? -quat_q[i] : quat_q[i];
			qb[i]   = rquat_q[i][QUAT_W-1] ? -rquat_q[i] : rquat_q[i];
			qneg[i] = quat_q[i][QUAT_W-1] ^ rquat_q[i][QUAT_W-1];
		end
	end

	assign go = (st_q == S_START);

	pks_dsmac #(
		.AW(DIST_W), .BW(TAN_W), .N(1), .SW(THW), .DIGIT_W(DIGIT_W)
	) u_thr (
		.clk(clk), .arst_n(arst_n), .start(go),
		.a_in(cur_dist_q), .b_in(tan_q), .neg_in(1'b0),
		.done(thr_done), .acc(thr)
	);

	pks_dsmac #(
		.AW(THW), .BW(THW), .N(1), .SW(TH2W), .DIGIT_W(DIGIT_W)
	) u_thr2 (
		.clk(clk), .arst_n(arst_n), .start(thr_done),
		.a_in(thr), .b_in(thr), .neg_in(1'b0),
		.done(th2_done), .acc(thr2)
	);

	pks_dsmac #(
		.AW(MW), .BW(MW), .N(3), .SW(D2W), .DIGIT_W(DIGIT_W)
	) u_d2 (
		.clk(clk), .arst_n(arst_n), .start(go),
		.a_in(mag), .b_in(mag), .neg_in(3'b000),
		.done(d2_done), .acc(d2)
	);

	pks_dsmac #(
		.AW(QUAT_W), .BW(QUAT_W), .N(4), .SW(DOTW), .DIGIT_W(DIGIT_W)
	) u_dot (
		.clk(clk), .arst_n(arst_n), .start(go),
		.a_in(qa), .b_in(qb), .neg_in(qneg),
		.done(dot_done), .acc(dot)
	);

	// squared offset moved up by 32 fraction bits against the squared threshold
	assign moved   = {d2, {POS_W{1'b0}}} >= CMPW'(thr2);
	assign adot    = dot[DOTW-1] ? -dot : dot;
	assign adot_cl = (adot > (DOTW'(1) << 30)) ? (DOTW'(1) << 30) : adot;
	assign turned  = adot_cl <= DOTW'({cos_q, 15'b0});

	always_comb begin
		case (kind_q)
			K_FIRST: take_pose = 1'b1;
			K_TEST:  take_pose = moved || turned;
			default: take_pose = 1'b0;
		endcase
	end

	assign reject_nx = (reject_q == '1) ? reject_q : reject_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tan_q  <= TAN_RST;
			cos_q  <= COS_RST;
			dmin_q <= DMIN_RST;
			dmax_q <= DMAX_RST;
			ddef_q <= DDEF_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TAN:  tan_q  <= cfg_data[TAN_W-1:0];
				REG_COS:  cos_q  <= cfg_data[COS_W-1:0];
				REG_DMIN: dmin_q <= cfg_data;
				REG_DMAX: dmax_q <= cfg_data;
				REG_DDEF: ddef_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			kind_q      <= K_RESTART;
			fin_q       <= '0;
			have_ref_q  <= 1'b0;
			cur_dist_q  <= DDEF_RST;
			reject_q    <= '0;
			rpos_q      <= '0;
			rquat_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (in_take) begin
						if (op) begin
							kind_q     <= K_RESTART;
							have_ref_q <= 1'b0;
							cur_dist_q <= ddef_q;
							reject_q   <= '0;
							rpos_q     <= '0;
							rquat_q    <= '0;
							st_q       <= S_FIN;
						end else begin
							if (scene_distance != '0) begin
								cur_dist_q <= dist_cl;
							end
							if (have_ref_q) begin
								kind_q <= K_TEST;
								st_q   <= S_START;
							end else begin
								kind_q <= K_FIRST;
								st_q   <= S_FIN;
							end
						end
					end
				end
				S_START: begin
					fin_q <= '0;
					st_q  <= S_WAIT;
				end
				S_WAIT: begin
					fin_q <= fin_q | {th2_done, d2_done, dot_done};
					if (fin_q == 3'b111) begin
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						st_q <= S_IDLE;
						if (kind_q != K_RESTART) begin
							if (take_pose) begin
								rpos_q     <= pos_q;
								rquat_q    <= quat_q;
								have_ref_q <= 1'b1;
							end else begin
								reject_q <= reject_nx;
							end
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pos_q  <= {pos_z, pos_y, pos_x};
			quat_q <= {quat_z, quat_y, quat_x, quat_w};
		end
		if (st_q == S_FIN && out_free) begin
			accepted_q <= take_pose;
			if (kind_q == K_RESTART || take_pose) begin
				count_q <= reject_q;
			end else begin
				count_q <= reject_nx;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = accepted_q;
	assign rejected_count = count_q;

endmodule
